[sv/sbnh_pkg.sv]
// ----------------------------------------------------------------------------
// Swept box nearest hit package
// Shared widths, constants and register indexes.
// ----------------------------------------------------------------------------
package sbnh_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int ID_WIDTH_DEF    = 16;
	localparam int TIME_W = 17;
	localparam int NORM_W = 18;
	localparam int CFG_IDX_W = 3;

	localparam logic [TIME_W-1:0] TIME_LIMIT = 17'd65543;
	localparam logic signed [NORM_W-1:0] NORM_POS  = 18'sd65536;
	localparam logic signed [NORM_W-1:0] NORM_NEG  = -18'sd65536;
	localparam logic signed [NORM_W-1:0] NORM_DIAG = 18'sd46341;
	localparam int EPS_Q = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MOVER_LOWER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVER_LOWER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOVER_UPPER_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOVER_UPPER_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_X        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_Y        = 3'd5;
endpackage

[sv/sbnh_if.sv]
// ----------------------------------------------------------------------------
// Swept box nearest hit channels
// Obstacle input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface sbnh_in_if #(parameter int CW = 32, parameter int IW = 16);
	logic valid;
	logic ready;
	logic signed [CW-1:0] obstacle_lower_x;
	logic signed [CW-1:0] obstacle_lower_y;
	logic signed [CW-1:0] obstacle_upper_x;
	logic signed [CW-1:0] obstacle_upper_y;
	logic [IW-1:0] obstacle_id;
	logic is_self;
	logic scan_start;
	modport source (output valid, obstacle_lower_x, obstacle_lower_y, obstacle_upper_x,
		obstacle_upper_y, obstacle_id, is_self, scan_start, input ready);
	modport sink (input valid, obstacle_lower_x, obstacle_lower_y, obstacle_upper_x,
		obstacle_upper_y, obstacle_id, is_self, scan_start, output ready);
endinterface

interface sbnh_out_if #(parameter int IW = 16);
	logic valid;
	logic ready;
	logic [16:0] item_time;
	logic any_hit;
	logic [IW-1:0] nearest_id;
	logic [16:0] nearest_time;
	logic signed [17:0] nearest_normal_x;
	logic signed [17:0] nearest_normal_y;
	modport source (output valid, item_time, any_hit, nearest_id, nearest_time,
		nearest_normal_x, nearest_normal_y, input ready);
	modport sink (input valid, item_time, any_hit, nearest_id, nearest_time,
		nearest_normal_x, nearest_normal_y, output ready);
endinterface

interface sbnh_cfg_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [CW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/swept_box_nearest_hit.sv]
// ----------------------------------------------------------------------------
// Swept box nearest hit
// Swept 2-D box against obstacle boxes, keeping the nearest hit of a scan.
// ----------------------------------------------------------------------------
// Channel  | Dir | Beat contents
// obs      | in  | obstacle box, id, self and scan start flags
// res      | out | item time and nearest-hit record
// cfg      | in  | register index and data
//
// An item goes through the accept, then for each axis the shared restoring
// divider (a set-up step, then one quotient bit a cycle), a step to pick
// the time, the moved-distance multiply for x then y, the check and the
// result beat. A self item skips to the result beat. arst_n clears the record,
// state and mover registers. The block takes no item while one is in progress
// or its result waits on res.ready. Configuration writes are always accepted.
module swept_box_nearest_hit
	import sbnh_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	sbnh_in_if.sink   obs,
	sbnh_out_if.source res,
	sbnh_cfg_if.sink  cfg
);
	localparam int CW = COORD_WIDTH;
	localparam int XW = CW + 2;
	localparam int MW = CW + TIME_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MULX = 3'd2;
	localparam logic [2:0] ST_MULY = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	logic signed [CW-1:0] mlx_q, mly_q, mux_q, muy_q, mvx_q, mvy_q;
	logic signed [CW-1:0] blx_q, bly_q, bux_q, buy_q;
	logic [ID_WIDTH-1:0] id_q;
	logic axis_q;
	logic [4:0] step_q;
	logic [XW-1:0] rem_q, dvs_q;
	logic [TIME_W-1:0] quo_q, qx_q, qy_q;
	logic vx_q, vy_q, ok_q;
	logic [TIME_W-1:0] t_q;
	logic signed [MW+1:0] dx_q, dy_q;
	logic [TIME_W-1:0] best_time_q, item_time_q;
	logic [ID_WIDTH-1:0] best_id_q;
	logic signed [NORM_W-1:0] best_nx_q, best_ny_q;
	logic hit_q;

	assign cfg.ready = 1'b1;
	assign obs.ready = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_OUT);
	assign res.item_time = item_time_q;
	assign res.any_hit = hit_q;
	assign res.nearest_id = best_id_q;
	assign res.nearest_time = best_time_q;
	assign res.nearest_normal_x = best_nx_q;
	assign res.nearest_normal_y = best_ny_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mlx_q <= '0; mly_q <= '0; mux_q <= '0; muy_q <= '0; mvx_q <= '0; mvy_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MOVER_LOWER_X: mlx_q <= cfg.data;
				REG_MOVER_LOWER_Y: mly_q <= cfg.data;
				REG_MOVER_UPPER_X: mux_q <= cfg.data;
				REG_MOVER_UPPER_Y: muy_q <= cfg.data;
				REG_MOVE_X:        mvx_q <= cfg.data;
				REG_MOVE_Y:        mvy_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Axis set-up: gap and offset magnitudes for the divider.
	logic signed [CW-1:0] a_lo, a_hi, b_lo, b_hi, mv;
	logic signed [CW:0] gap;
	logic [XW-1:0] ag, am;
	logic setup_ok;
	always_comb begin
		a_lo = axis_q ? mly_q : mlx_q;
		a_hi = axis_q ? muy_q : mux_q;
		b_lo = axis_q ? bly_q : blx_q;
		b_hi = axis_q ? buy_q : bux_q;
		mv   = axis_q ? mvy_q : mvx_q;
		gap  = (mv > 0) ? (CW+1)'(b_lo) - (CW+1)'(a_hi) : (CW+1)'(b_hi) - (CW+1)'(a_lo);
		ag   = gap[CW] ? XW'(-gap) : XW'(gap);
		am   = mv[CW-1] ? XW'(-(CW+1)'(mv)) : XW'((CW+1)'(mv));
		setup_ok = (mv != 0) && (gap != 0) && ((gap > 0) == (mv > 0))
			&& (ag < {am[XW-2:0], 1'b0});
	end

	// Shared restoring divider step.
	logic [XW-1:0] rem_sh;
	logic rem_ge;
	assign rem_sh = {rem_q[XW-2:0], 1'b0};
	assign rem_ge = rem_sh >= dvs_q;

	// Moved distance: one axis a cycle on a single multiplier.
	logic [CW:0] mag_mv;
	logic [MW:0] prod;
	logic signed [MW+1:0] move_d;
	assign mag_mv = mv[CW-1] ? -(CW+1)'(mv) : (CW+1)'(mv);
	assign prod = (MW+1)'(mag_mv) * (MW+1)'(t_q);
	assign move_d = mv[CW-1] ? -(MW+2)'(prod >> 16) : (MW+2)'(prod >> 16);

	logic signed [MW+3:0] lx, hx, lyv, hyv;
	logic miss;
	always_comb begin
		lx  = (MW+4)'(mlx_q) + (MW+4)'(dx_q);
		hx  = (MW+4)'(mux_q) + (MW+4)'(dx_q);
		lyv = (MW+4)'(mly_q) + (MW+4)'(dy_q);
		hyv = (MW+4)'(muy_q) + (MW+4)'(dy_q);
		miss = (lx > (MW+4)'(bux_q) + (MW+4)'(EPS_Q))
			|| (hx < (MW+4)'(blx_q) - (MW+4)'(EPS_Q))
			|| (lyv > (MW+4)'(buy_q) + (MW+4)'(EPS_Q))
			|| (hyv < (MW+4)'(bly_q) - (MW+4)'(EPS_Q));
	end

	logic [TIME_W-1:0] qfin;
	logic qok;
	assign qfin = {quo_q[TIME_W-2:0], rem_ge};
	assign qok = ok_q && (qfin != '0) && (qfin < TIME_LIMIT);

	logic [TIME_W-1:0] tsel;
	logic signed [NORM_W-1:0] nx, ny;
	always_comb begin
		tsel = '0; nx = '0; ny = '0;
		if (vx_q) begin
			tsel = qx_q;
			nx = (mvx_q > 0) ? NORM_NEG : NORM_POS;
		end
		if (vy_q && qy_q > tsel) begin
			tsel = qy_q;
			nx = '0;
			ny = (mvy_q > 0) ? NORM_NEG : NORM_POS;
		end
		if (vx_q && vy_q && qx_q == qy_q) begin
			nx = NORM_DIAG;
			ny = NORM_DIAG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			best_time_q <= TIME_LIMIT;
			best_id_q <= '0;
			best_nx_q <= '0;
			best_ny_q <= '0;
			hit_q <= 1'b0;
			item_time_q <= '0;
			axis_q <= 1'b0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (obs.valid) begin
					blx_q <= obs.obstacle_lower_x;
					bly_q <= obs.obstacle_lower_y;
					bux_q <= obs.obstacle_upper_x;
					buy_q <= obs.obstacle_upper_y;
					id_q  <= obs.obstacle_id;
					item_time_q <= '0;
					if (obs.scan_start) begin
						best_time_q <= TIME_LIMIT;
						best_id_q <= '0;
						best_nx_q <= '0;
						best_ny_q <= '0;
						hit_q <= 1'b0;
					end
					axis_q <= 1'b0;
					step_q <= '0;
					state_q <= obs.is_self ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (step_q == 5'd0) begin
						ok_q  <= setup_ok;
						dvs_q <= am;
						quo_q <= TIME_W'(ag >= am);
						rem_q <= (ag >= am) ? ag - am : ag;
						step_q <= 5'd1;
					end else begin
						rem_q <= rem_ge ? rem_sh - dvs_q : rem_sh;
						quo_q <= qfin;
						if (step_q == 5'd16) begin
							step_q <= '0;
							if (!axis_q) begin
								qx_q <= qfin; vx_q <= qok; axis_q <= 1'b1;
							end else begin
								qy_q <= qfin; vy_q <= qok; axis_q <= 1'b0;
							end
						end else begin
							step_q <= step_q + 5'd1;
						end
						if (step_q == 5'd16 && axis_q) begin
							state_q <= ST_MULX;
						end
					end
				end
				ST_MULX: begin
					t_q <= tsel;
					axis_q <= 1'b0;
					state_q <= ST_MULY;
				end
				ST_MULY: begin
					// axis_q selects mv; x distance first, then y.
					if (!axis_q) begin
						dx_q <= move_d; axis_q <= 1'b1;
					end else begin
						dy_q <= move_d; axis_q <= 1'b0; state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (t_q != '0 && !miss) begin
						item_time_q <= t_q;
						if (t_q < best_time_q) begin
							best_time_q <= t_q;
							best_id_q <= id_q;
							best_nx_q <= nx;
							best_ny_q <= ny;
							hit_q <= 1'b1;
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (res.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		obs.ready |-> !res.valid) else $error("accept while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> best_time_q < TIME_LIMIT) else $error("hit without time");
	assert property (@(posedge clk) disable iff (!arst_n)
		!hit_q |-> best_time_q == TIME_LIMIT) else $error("record not clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid) else $error("result dropped");
endmodule

[bench/swept_box_nearest_hit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept box nearest hit testbench
// Drives obstacle beats under several mover settings, predicts each result
// beat from its own model of the sweep and compares it field by field.
// ----------------------------------------------------------------------------
module swept_box_nearest_hit_tb;
	import sbnh_pkg::*;

	localparam int CW = 32;
	localparam int IW = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [CW-1:0] lx;
		logic signed [CW-1:0] ly;
		logic signed [CW-1:0] ux;
		logic signed [CW-1:0] uy;
		logic [IW-1:0] id;
		logic self_flag;
		logic start;
	} obstacle_t;

	typedef struct packed {
		logic [16:0] item_time;
		logic any_hit;
		logic [IW-1:0] nearest_id;
		logic [16:0] nearest_time;
		logic signed [17:0] nx;
		logic signed [17:0] ny;
	} hit_report_t;

	typedef struct {
		obstacle_t ob;
		bit has_known;
		hit_report_t known;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sbnh_in_if #(.CW(CW), .IW(IW)) obs ();
	sbnh_out_if #(.IW(IW)) res ();
	sbnh_cfg_if #(.CW(CW)) cfg ();

	swept_box_nearest_hit #(.COORD_WIDTH(CW), .ID_WIDTH(IW)) i_dut (
		.clk(clk), .arst_n(arst_n), .obs(obs), .res(res), .cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: mover registers and nearest-hit record.
	longint box_reg [6];
	logic [16:0] rec_time;
	logic [IW-1:0] rec_id;
	logic signed [17:0] rec_nx, rec_ny;
	bit rec_hit;

	hit_report_t pending_reports [$];
	int mismatches = 0;
	int cycles = 0;
	bit quiet = 0;
	bit hold_off = 0;

	function automatic longint mag64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit entry_time(longint alo, longint ahi, longint blo, longint bhi,
			longint mv, output longint q);
		longint gap, ag, am, r;
		q = 0;
		if (mv == 0) return 0;
		gap = mv > 0 ? blo - ahi : bhi - alo;
		if (gap == 0 || ((gap > 0) != (mv > 0))) return 0;
		ag = mag64(gap);
		am = mag64(mv);
		if (ag >= 2 * am) return 0;
		q = ag >= am ? 1 : 0;
		r = ag - q * am;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= am) begin
				r -= am;
				q |= 1;
			end
		end
		if (q == 0 || q >= TIME_LIMIT) begin
			q = 0;
			return 0;
		end
		return 1;
	endfunction

	function automatic longint travel(longint mv, longint t);
		longint am, p;
		am = mag64(mv);
		p = am * (t >> 16) + ((am * (t & 'hFFFF)) >> 16);
		return mv < 0 ? -p : p;
	endfunction

	function automatic bit misses(longint alo, longint ahi, longint blo, longint bhi,
			longint d);
		return (alo + d > bhi + EPS_Q) || (ahi + d < blo - EPS_Q);
	endfunction

	function automatic hit_report_t sweep_obstacle(obstacle_t ob);
		longint qx, qy, t, bx0, by0, bx1, by1;
		longint nxv, nyv;
		bit vx, vy;
		hit_report_t r;
		bx0 = ob.lx; by0 = ob.ly; bx1 = ob.ux; by1 = ob.uy;
		t = 0; nxv = 0; nyv = 0;
		if (ob.start) begin
			rec_time = TIME_LIMIT; rec_id = '0; rec_nx = '0; rec_ny = '0; rec_hit = 0;
		end
		if (!ob.self_flag) begin
			vx = entry_time(box_reg[REG_MOVER_LOWER_X], box_reg[REG_MOVER_UPPER_X], bx0, bx1,
				box_reg[REG_MOVE_X], qx);
			vy = entry_time(box_reg[REG_MOVER_LOWER_Y], box_reg[REG_MOVER_UPPER_Y], by0, by1,
				box_reg[REG_MOVE_Y], qy);
			if (vx) begin
				t = qx;
				nxv = box_reg[REG_MOVE_X] > 0 ? -65536 : 65536;
			end
			if (vy && qy > t) begin
				t = qy;
				nxv = 0;
				nyv = box_reg[REG_MOVE_Y] > 0 ? -65536 : 65536;
			end
			if (t > 0) begin
				if (misses(box_reg[REG_MOVER_LOWER_X], box_reg[REG_MOVER_UPPER_X], bx0, bx1,
						travel(box_reg[REG_MOVE_X], t)) ||
					misses(box_reg[REG_MOVER_LOWER_Y], box_reg[REG_MOVER_UPPER_Y], by0, by1,
						travel(box_reg[REG_MOVE_Y], t)))
					t = 0;
				else if (vx && vy && qx == qy) begin
					nxv = 46341;
					nyv = 46341;
				end
			end
			if (t > 0 && t < rec_time) begin
				rec_time = 17'(t);
				rec_id = ob.id;
				rec_nx = 18'(nxv);
				rec_ny = 18'(nyv);
				rec_hit = 1;
			end
		end
		r.item_time = 17'(t);
		r.any_hit = rec_hit;
		r.nearest_id = rec_id;
		r.nearest_time = rec_time;
		r.nx = rec_nx;
		r.ny = rec_ny;
		return r;
	endfunction

	// Leaves valid high; the caller drops it after its last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [CW-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		box_reg[idx] = longint'(val);
	endtask

	task automatic set_mover(longint lx, longint ly, longint ux, longint uy,
			longint mx, longint my);
		write_reg(REG_MOVER_LOWER_X, CW'(lx));
		write_reg(REG_MOVER_LOWER_Y, CW'(ly));
		write_reg(REG_MOVER_UPPER_X, CW'(ux));
		write_reg(REG_MOVER_UPPER_Y, CW'(uy));
		write_reg(REG_MOVE_X, CW'(mx));
		write_reg(REG_MOVE_Y, CW'(my));
		cfg.valid <= 1'b0;
	endtask

	// Stops offering, waits for the expected results to drain, then lets the block settle.
	task automatic drain();
		obs.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic send_obstacle(obstacle_t ob, bit has_known, hit_report_t known);
		hit_report_t p;
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			obs.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		obs.valid <= 1'b1;
		{obs.obstacle_lower_x, obs.obstacle_lower_y, obs.obstacle_upper_x,
			obs.obstacle_upper_y, obs.obstacle_id, obs.is_self, obs.scan_start} <= ob;
		do @(posedge clk); while (!obs.ready);
		p = sweep_obstacle(ob);
		if (has_known && p != known) begin
			mismatches++;
			if (mismatches <= 10)
				$display("directed row disagrees with predictor: table %h model %h",
					known, p);
		end
		pending_reports = {pending_reports, p};
	endtask

	function automatic obstacle_t make_obs(longint lx, longint ly, longint ux, longint uy,
			int id, bit s, bit st);
		obstacle_t o;
		o.lx = CW'(lx); o.ly = CW'(ly); o.ux = CW'(ux); o.uy = CW'(uy);
		o.id = IW'(id); o.self_flag = s; o.start = st;
		return o;
	endfunction

	// Obstacle placed near the path of the mover, with random jitter.
	function automatic obstacle_t near_obstacle();
		longint cx, cy, w, h, mx, my;
		mx = box_reg[REG_MOVE_X];
		my = box_reg[REG_MOVE_Y];
		cx = box_reg[REG_MOVER_UPPER_X] + (mx * longint'($urandom_range(0, 130))) / 100
			+ $signed(longint'($urandom_range(0, 8 << 16))) - (4 << 16);
		cy = box_reg[REG_MOVER_UPPER_Y] + (my * longint'($urandom_range(0, 130))) / 100
			+ $signed(longint'($urandom_range(0, 8 << 16))) - (4 << 16);
		w = $urandom_range(1, 6 << 16);
		h = $urandom_range(1, 6 << 16);
		return make_obs(cx - w, cy - h, cx + w, cy + h, $urandom_range(0, 65535),
			$urandom_range(0, 19) == 0, $urandom_range(0, 15) == 0);
	endfunction

	function automatic obstacle_t noise_obstacle();
		return make_obs($signed($urandom()), $signed($urandom()), $signed($urandom()),
			$signed($urandom()), $urandom_range(0, 65535), $urandom_range(0, 1) == 1,
			$urandom_range(0, 1) == 1);
	endfunction

	// Result sink: random stalls, one long hold-off, none near the end.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_off) begin
			res.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		hit_report_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result beat with nothing expected");
			end else begin
				want = pending_reports.pop_front();
				if (want.item_time !== res.item_time || want.any_hit !== res.any_hit ||
						want.nearest_id !== res.nearest_id ||
						want.nearest_time !== res.nearest_time ||
						want.nx !== res.nearest_normal_x || want.ny !== res.nearest_normal_y) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp t=%0d hit=%0d id=%0d nt=%0d n=(%0d,%0d)",
							want.item_time, want.any_hit, want.nearest_id, want.nearest_time,
							want.nx, want.ny);
						$display("          got t=%0d hit=%0d id=%0d nt=%0d n=(%0d,%0d)",
							res.item_time, res.any_hit, res.nearest_id, res.nearest_time,
							res.nearest_normal_x, res.nearest_normal_y);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** swept_box_nearest_hit: FAILED **");
			$finish;
		end
	end

	stim_row_t directed [$];

	task automatic add_row(obstacle_t ob, bit k, hit_report_t r);
		stim_row_t s;
		s.ob = ob; s.has_known = k; s.known = r;
		directed = {directed, s};
	endtask

	initial begin
		hit_report_t none_yet, nk;
		int pressure_at;
		obs.valid = 1'b0;
		{obs.obstacle_lower_x, obs.obstacle_lower_y, obs.obstacle_upper_x,
			obs.obstacle_upper_y, obs.obstacle_id, obs.is_self, obs.scan_start} = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_MOVER_LOWER_X;
		cfg.data = '0;
		for (int i = 0; i < 6; i++) box_reg[i] = 0;
		rec_time = TIME_LIMIT; rec_id = '0; rec_nx = '0; rec_ny = '0; rec_hit = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight after reset the move is zero, so nothing can be hit.
		none_yet = '{item_time: 0, any_hit: 0, nearest_id: 0, nearest_time: TIME_LIMIT,
			nx: 0, ny: 0};
		nk = none_yet;
		add_row(make_obs(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
			16'hFFFF, 0, 1), 1, none_yet);
		add_row(make_obs(0, 0, 0, 0, 0, 1, 0), 1, none_yet);
		foreach (directed[i]) send_obstacle(directed[i].ob, directed[i].has_known,
			directed[i].known);
		directed.delete();
		drain();

		// Unit box moving right and up by 4; hits in x, in y, diagonally, plus misses and self items.
		set_mover(0, 0, 1 << 16, 1 << 16, 4 << 16, 4 << 16);
		add_row(make_obs(3 << 16, 0, 4 << 16, 1 << 16, 1, 0, 1), 0, nk);
		add_row(make_obs(0, 2 << 16, 1 << 16, 3 << 16, 2, 0, 0), 0, nk);
		add_row(make_obs(2 << 16, 2 << 16, 3 << 16, 3 << 16, 3, 0, 0), 0, nk);
		add_row(make_obs(2 << 16, 2 << 16, 3 << 16, 3 << 16, 4, 1, 0), 0, nk);
		add_row(make_obs(5 << 16, 5 << 16, 6 << 16, 6 << 16, 5, 0, 0), 0, nk);
		add_row(make_obs(9 << 16, 0, 10 << 16, 1 << 16, 6, 0, 0), 0, nk);
		add_row(make_obs(3 << 16, 50 << 16, 4 << 16, 51 << 16, 7, 0, 0), 0, nk);
		add_row(make_obs(4 << 16, 4 << 16, 0, 0, 8, 0, 0), 0, nk);
		add_row(make_obs(1 << 16, 0, 2 << 16, 1 << 16, 9, 1, 1), 0, nk);
		foreach (directed[i]) send_obstacle(directed[i].ob, directed[i].has_known,
			directed[i].known);
		directed.delete();
		drain();

		// Negative motion, zero y move, and extreme register values.
		set_mover(-(1 << 16), -(1 << 16), 0, 0, -(8 << 16), 0);
		add_row(make_obs(-(5 << 16), -(1 << 16), -(4 << 16), 0, 10, 0, 1), 0, nk);
		add_row(make_obs(-(3 << 16), -(1 << 16), -(2 << 16), 0, 11, 0, 0), 0, nk);
		add_row(make_obs(-(20 << 16), -(1 << 16), -(19 << 16), 0, 12, 0, 0), 0, nk);
		foreach (directed[i]) send_obstacle(directed[i].ob, directed[i].has_known,
			directed[i].known);
		directed.delete();
		drain();
		set_mover(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, 32'sh80000000);
		add_row(make_obs(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			16'hFFFF, 0, 1), 0, nk);
		add_row(make_obs(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			0, 0, 0), 0, nk);
		foreach (directed[i]) send_obstacle(directed[i].ob, directed[i].has_known,
			directed[i].known);
		directed.delete();
		drain();

		// Random phases: mostly obstacles along the sweep path, some noise.
		pressure_at = $urandom_range(20, 60);
		for (int ph = 0; ph < 7; ph++) begin
			longint w, h;
			w = $urandom_range(1, 4 << 16);
			h = $urandom_range(1, 4 << 16);
			set_mover(-w, -h, w, h,
				$signed(longint'($urandom_range(0, 40 << 16))) - (20 << 16),
				$urandom_range(0, 3) == 0 ? 0 :
				$signed(longint'($urandom_range(0, 40 << 16))) - (20 << 16));
			if (ph == 6) quiet = 1;
			for (int n = 0; n < 100; n++) begin
				if (ph == 0 && n == pressure_at) begin
					fork
						begin
							hold_off = 1;
							repeat (400) @(posedge clk);
							hold_off = 0;
						end
					join_none
				end
				send_obstacle($urandom_range(0, 4) == 0 ? noise_obstacle() : near_obstacle(),
					0, nk);
			end
			drain();
		end

		if (mismatches == 0)
			$display("** swept_box_nearest_hit: PASSED **");
		else
			$display("** swept_box_nearest_hit: FAILED **");
		$finish;
	end
endmodule
